// File: rtl/core/best_fit_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Best-fit block allocator assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BFA_ASSERT_IMPL(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("bfa assertion failed");
// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("bfa assertion failed");
`else
`define BFA_ASSERT_IMPL(lbl, clk_i, rst_i, ante, cons)
`define BFA_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)
`endif

`endif

// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Field widths, operation codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int SLOT_FW    = 3;
  localparam int AMOUNT_W   = 16;
  localparam int ID_W       = 8;
  localparam int SIZE_OUT_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;    // write block size, mark slot free
    logic start;   // latch request, clear best
    logic scan;    // read one slot, advance counter
    logic commit;  // load output register, clear chosen free bit
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// File: rtl/core/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Fixed-partition allocator: loads block sizes, grants best-fit free blocks.
// ----------------------------------------------------------------------------
// A load item (tuser = 0) writes a block size into a slot and marks it free;
// the next item can follow right away. An allocate item (tuser = 1) scans the
// size memory one slot per cycle through its single registered read port; the
// last read is compared in ST_LAST, and in ST_RESULT the result is loaded into
// the output register once the previous result there has been read. Only then
// is the next item taken. Among free blocks at least as large as the request
// the one with the least space over wins, the lowest slot on ties. Loads to
// slots at or beyond NUM_SLOTS are dropped. After reset no block is free.
// ----------------------------------------------------------------------------
`include "best_fit_block_allocator_macros.svh"

module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SIZE_BITS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // slot[2:0], amount[18:3], request_id[26:19]
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // result_id[7:0], chosen_slot[10:8],
                                           // chosen_size[26:11], leftover[42:27]
  output logic                  m_tuser    // granted
);

  cmd_t    cmd;
  status_t status;

  logic [ID_W-1:0]       out_id;
  logic [SLOT_FW-1:0]    out_slot;
  logic [SIZE_OUT_W-1:0] out_size;
  logic [SIZE_OUT_W-1:0] out_left;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_func   (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  bfa_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_slot     (s_tdata[2:0]),
    .in_amount   (s_tdata[18:3]),
    .in_id       (s_tdata[26:19]),
    .out_id      (out_id),
    .out_granted (m_tuser),
    .out_slot    (out_slot),
    .out_size    (out_size),
    .out_left    (out_left)
  );

  assign m_tdata = {5'b0, out_left, out_size, out_slot, out_id};

  // a refused request carries no slot, size or leftover
  `BFA_ASSERT_IMPL(a_deny_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[42:8] == '0)
  // an allocate item blocks the input until its result is committed
  `BFA_ASSERT_NEXT(a_alloc_busy, clk, rst, s_tvalid && s_tready && s_tuser, !s_tready)
  // a granted slot exists in the table
  `BFA_ASSERT_IMPL(a_slot_range, clk, rst, m_tvalid && m_tuser, 32'(m_tdata[10:8]) < NUM_SLOTS)

endmodule

// File: rtl/core/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator controller
// Sequences load, scan and result commit; owns the output valid flag.
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_func,
  output logic    s_tready,
  input  logic    m_tready,
  output logic    m_tvalid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_func == FUNC_ALLOC) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_LAST;
        end
      end
      // last read data is compared here
      ST_LAST: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/bfa_dpath.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator datapath
// Size memory, free bits, one-slot-per-cycle best-fit compare, result register.
// ----------------------------------------------------------------------------
module bfa_dpath
  import bfa_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int SIZE_BITS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [SLOT_FW-1:0]    in_slot,
  input  logic [AMOUNT_W-1:0]   in_amount,
  input  logic [ID_W-1:0]       in_id,
  output logic [ID_W-1:0]       out_id,
  output logic                  out_granted,
  output logic [SLOT_FW-1:0]    out_slot,
  output logic [SIZE_OUT_W-1:0] out_size,
  output logic [SIZE_OUT_W-1:0] out_left
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  logic [SIZE_BITS-1:0] size_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] free;

  logic [SLOT_W-1:0]    cnt;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_free;
  logic                 rd_vld;
  logic [SLOT_W-1:0]    rd_idx;

  logic [SIZE_BITS-1:0] req_amt;
  logic [ID_W-1:0]      req_id;
  logic                 found;
  logic [SLOT_W-1:0]    best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] best_left;

  logic [SLOT_W+SLOT_FW-1:0]     slot_ext;
  logic [SLOT_W-1:0]             wr_idx;
  logic                          slot_ok;
  logic [SIZE_BITS+AMOUNT_W-1:0] amt_ext;
  logic [SIZE_BITS-1:0]          amt;
  logic                          fits;
  logic [SIZE_BITS-1:0]          left;
  logic                          better;
  logic [SIZE_BITS+SIZE_OUT_W-1:0] size_ext;
  logic [SIZE_BITS+SIZE_OUT_W-1:0] left_ext;
  logic [SLOT_W+SLOT_FW-1:0]       best_ext;

  assign slot_ext = {{SLOT_W{1'b0}}, in_slot};
  assign wr_idx   = slot_ext[SLOT_W-1:0];
  assign slot_ok  = ({5'b0, in_slot} < 8'(NUM_SLOTS));
  assign amt_ext  = {{SIZE_BITS{1'b0}}, in_amount};
  assign amt      = amt_ext[SIZE_BITS-1:0];

  assign status.scan_last = (cnt == LAST_IDX);

  // size memory: one write port (load), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      size_mem[wr_idx] <= amt;
    end
    rd_data <= size_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= '0;
    end else if (cmd.load && slot_ok) begin
      free[wr_idx] <= 1'b1;
    end else if (cmd.commit && found) begin
      free[best_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    rd_free <= free[cnt];
    rd_idx  <= cnt;
    if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign fits   = rd_vld && rd_free && (rd_data >= req_amt);
  assign left   = rd_data - req_amt;
  // strict less-than keeps the lowest slot on ties
  assign better = !found || (left < best_left);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_amt <= amt;
      req_id  <= in_id;
      found   <= 1'b0;
    end else if (fits && better) begin
      found     <= 1'b1;
      best_idx  <= rd_idx;
      best_size <= rd_data;
      best_left <= left;
    end
  end

  assign size_ext = {{SIZE_OUT_W{1'b0}}, best_size};
  assign left_ext = {{SIZE_OUT_W{1'b0}}, best_left};
  assign best_ext = {{SLOT_FW{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_id      <= req_id;
      out_granted <= found;
      out_slot    <= found ? best_ext[SLOT_FW-1:0] : '0;
      out_size    <= found ? size_ext[SIZE_OUT_W-1:0] : '0;
      out_left    <= found ? left_ext[SIZE_OUT_W-1:0] : '0;
    end
  end

endmodule

// File: verif/bfa_checker.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator checker
// Watches both stream channels and keeps its own copy of the block table. It
// predicts each allocation reply in order and compares it field by field.
// ----------------------------------------------------------------------------
module bfa_checker
  import bfa_pkg::*;
#(
  parameter int NUM_SLOTS = 8
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  output int                    errors,
  output int                    pending,
  output int                    grants,
  output int                    refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic                  granted;
    logic [SLOT_FW-1:0]    slot;
    logic [SIZE_OUT_W-1:0] size;
    logic [SIZE_OUT_W-1:0] left;
  } grant_t;

  logic [AMOUNT_W-1:0] block_size [NUM_SLOTS];
  logic                block_free [NUM_SLOTS];
  grant_t              grant_q [$];
  int                  fails;
  int                  n_grant;
  int                  n_refuse;

  // smallest leftover among free blocks that fit; strict compare keeps the lowest slot
  function automatic grant_t best_fit(input logic [ID_W-1:0] id,
                                      input logic [AMOUNT_W-1:0] want);
    grant_t              g;
    logic [AMOUNT_W-1:0] gap;
    g = '0;
    g.id = id;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (block_free[k] && block_size[k] >= want) begin
        gap = block_size[k] - want;
        if (!g.granted || gap < g.left) begin
          g.granted = 1'b1;
          g.slot    = k[SLOT_FW-1:0];
          g.size    = block_size[k];
          g.left    = gap;
        end
      end
    end
    return g;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    grant_t               want_g;
    logic [SLOT_FW-1:0]   ld_slot;
    if (rst) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        block_size[k] = '0;
        block_free[k] = 1'b0;
      end
      grant_q.delete();
      fails    = 0;
      n_grant  = 0;
      n_refuse = 0;
    end else begin
      // reply side first: a reply never belongs to an item taken on the same edge
      if (m_tvalid && m_tready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got %0h/%0b",
                   $time, m_tdata, m_tuser);
          fails++;
        end else begin
          want_g = grant_q.pop_front();
          check_field("result_id",   32'(want_g.id),      32'(m_tdata[7:0]));
          check_field("granted",     32'(want_g.granted), 32'(m_tuser));
          check_field("chosen_slot", 32'(want_g.slot),    32'(m_tdata[10:8]));
          check_field("chosen_size", 32'(want_g.size),    32'(m_tdata[26:11]));
          check_field("leftover",    32'(want_g.left),    32'(m_tdata[42:27]));
          if (want_g.granted) n_grant++;
          else n_refuse++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_LOAD) begin
          ld_slot = s_tdata[2:0];
          if (32'(ld_slot) < NUM_SLOTS) begin
            block_size[ld_slot] = s_tdata[18:3];
            block_free[ld_slot] = 1'b1;
          end
        end else begin
          want_g = best_fit(s_tdata[26:19], s_tdata[18:3]);
          if (want_g.granted) block_free[want_g.slot] = 1'b0;
          grant_q.push_back(want_g);
        end
      end
    end
    errors   <= fails;
    pending  <= grant_q.size();
    grants   <= n_grant;
    refusals <= n_refuse;
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Directed table loads and requests (ties, zero and full-size requests,
// refusals, reloads of taken slots), then random rounds of loads followed by
// requests sized near the loaded blocks, with random gaps and stalls on both
// streams, a long output stall and full drains. Checking is in bfa_checker.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int errors;
  int pending;
  int grants;
  int refusals;

  bit                  calm;        // no random gaps on either side while set
  bit                  hold_long;
  int                  long_holds;
  int                  n_items;
  int                  n_loads;
  int                  n_allocs;
  int                  stall_cnt;
  logic [AMOUNT_W-1:0] shadow [8];  // last size loaded per slot, for shaping requests

  best_fit_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bfa_checker chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending),
    .grants   (grants),
    .refusals (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // reply side: random stall before each item, one long stall on request
  initial begin
    int hold;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
        long_holds++;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  task automatic send(input logic op, input logic [SLOT_FW-1:0] sl,
                      input logic [AMOUNT_W-1:0] amt, input logic [ID_W-1:0] id);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W-27){1'b0}}, id, amt, sl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (op == FUNC_LOAD) begin
      n_loads++;
      shadow[sl] = amt;
    end else begin
      n_allocs++;
    end
  endtask

  // stop offering, then wait for every expected reply
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                  round;
    int                  nl;
    int                  na;
    int                  r;
    logic [SLOT_FW-1:0]  sl;
    logic [AMOUNT_W-1:0] amt;
    s_tvalid = 1'b0;
    s_tuser  = FUNC_LOAD;
    s_tdata  = '0;
    calm = 1'b0;
    hold_long = 1'b0;
    for (int k = 0; k < 8; k++) shadow[k] = '0;
    @(posedge clk iff !rst);

    // nothing free yet: zero request is refused
    send(FUNC_ALLOC, 3'd0, 16'd0, 8'h00);
    send(FUNC_LOAD, 3'd0, 16'd100, 8'h00);
    send(FUNC_LOAD, 3'd1, 16'd40, 8'h00);
    send(FUNC_LOAD, 3'd2, 16'd40, 8'h00);
    send(FUNC_LOAD, 3'd3, 16'hFFFF, 8'h00);
    send(FUNC_LOAD, 3'd4, 16'd0, 8'h00);
    send(FUNC_LOAD, 3'd5, 16'h5555, 8'h00);
    send(FUNC_LOAD, 3'd6, 16'hAAAA, 8'h00);
    send(FUNC_LOAD, 3'd7, 16'd1000, 8'hFF);
    send(FUNC_ALLOC, 3'd7, 16'd0, 8'hFF);      // zero request takes the empty block
    send(FUNC_ALLOC, 3'd0, 16'd40, 8'hAA);     // tie, slot 1 wins
    send(FUNC_ALLOC, 3'd0, 16'd40, 8'h55);     // then slot 2
    send(FUNC_ALLOC, 3'd0, 16'd40, 8'h01);     // slot 0, 60 over
    send(FUNC_ALLOC, 3'd0, 16'hFFFF, 8'h80);   // exact full size
    send(FUNC_ALLOC, 3'd0, 16'hFFFF, 8'h7F);   // nothing that big left
    send(FUNC_LOAD, 3'd1, 16'd7, 8'h00);       // reload a taken slot
    send(FUNC_ALLOC, 3'd0, 16'd5, 8'h02);
    send(FUNC_LOAD, 3'd7, 16'd1000, 8'h00);    // reload a free slot
    send(FUNC_ALLOC, 3'd0, 16'd1, 8'h03);
    send(FUNC_ALLOC, 3'd0, 16'hAAAB, 8'h04);   // refused, table unchanged
    send(FUNC_ALLOC, 3'd0, 16'hAAAA, 8'h05);
    drain();

    round = 0;
    while (n_items < 1100) begin
      round++;
      calm = ($urandom_range(0, 4) == 0);
      if (round % 37 == 5) hold_long = 1'b1;
      nl = ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(0, 5);
      repeat (nl) begin
        sl = SLOT_FW'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        case (r)
          0:          amt = 16'd0;
          1:          amt = 16'hFFFF;
          2, 3, 4, 5: amt = AMOUNT_W'($urandom_range(0, 63));
          6, 7:       amt = AMOUNT_W'($urandom_range(0, 4095));
          default:    amt = AMOUNT_W'($urandom_range(0, 65535));
        endcase
        send(FUNC_LOAD, sl, amt, ID_W'($urandom_range(0, 255)));
      end
      na = (round % 37 == 5) ? 8 : $urandom_range(1, 10);
      repeat (na) begin
        if ($urandom_range(0, 19) == 0) begin
          // noise: any field value, either operation
          send(1'($urandom_range(0, 1)), SLOT_FW'($urandom_range(0, 7)),
               AMOUNT_W'($urandom_range(0, 65535)), ID_W'($urandom_range(0, 255)));
        end else begin
          sl = SLOT_FW'($urandom_range(0, 7));
          r = $urandom_range(0, 9);
          case (r)
            0:          amt = 16'd0;
            1, 2, 3, 4: amt = (shadow[sl] >= 16'd2)
                              ? shadow[sl] - AMOUNT_W'($urandom_range(0, 2))
                              : shadow[sl];
            5:          amt = (shadow[sl] == 16'hFFFF) ? shadow[sl] : shadow[sl] + 16'd1;
            6, 7:       amt = AMOUNT_W'($urandom_range(0, 63));
            8:          amt = 16'hFFFF;
            default:    amt = AMOUNT_W'($urandom_range(0, 65535));
          endcase
          send(FUNC_ALLOC, SLOT_FW'($urandom_range(0, 7)), amt,
               ID_W'($urandom_range(0, 255)));
        end
      end
      if (round % 23 == 11) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d items: %0d table loads, %0d allocation requests.",
             n_items, n_loads, n_allocs);
    $display("Checked %0d grants and %0d refusals, %0d long output stalls.",
             grants, refusals, long_holds);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: best_fit_block_allocator.f
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dpath.sv
rtl/core/best_fit_block_allocator.sv
verif/bfa_checker.sv
verif/tb.sv
